// ===== rtl/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int MODE_W       = 2;
  localparam int POS_W        = 4;
  localparam int LEN_W        = 5;
  localparam int RES_W        = 1 + POS_W + DATA_W + 1 + LEN_W;
  localparam int OUT_TDATA_W  = ((RES_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;    // capture word and compare against stored entries
    logic commit;  // shift array, update count, register result
  } cmd_t;

endpackage

// ===== rtl/spq_dp.sv =====
// datapath: sorted entry array, parallel compare flags, count and result register
module spq_dp #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  spq_pkg::cmd_t                      cmd,
  input  logic [spq_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [spq_pkg::DATA_W-1:0]  in_value,
  output logic                               res_success,
  output logic [spq_pkg::POS_W-1:0]          res_position,
  output logic signed [spq_pkg::DATA_W-1:0]  res_head,
  output logic                               res_empty,
  output logic [spq_pkg::LEN_W-1:0]          res_length
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [spq_pkg::DATA_W-1:0]        ent_r   [CAPACITY];
  logic [spq_pkg::DATA_W-1:0]        ent_nxt [CAPACITY];
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [spq_pkg::MODE_W-1:0]        op_r;
  logic signed [spq_pkg::DATA_W-1:0] val_r;
  logic [CAPACITY-1:0]               gt_r, gt_nxt;
  logic [CAPACITY-1:0]               eq_r, eq_nxt;

  logic [CAPACITY-1:0] bnd;
  logic [IDX_W-1:0]    pos_idx;
  logic                hit;
  logic                full;
  logic                ok;
  logic [31:0]         pos_w;
  logic [31:0]         len_w;

  // per-entry compare, entries past the count never flag
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt_nxt[i] = (CNT_W'(i) < count_r) && ($signed(ent_r[i]) > in_value);
      eq_nxt[i] = (CNT_W'(i) < count_r) && (ent_r[i] == in_value);
    end
  end

  // gt flags form a prefix, so the boundary is one-hot (or empty when the queue is full and all are larger)
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        bnd[i] = ~gt_r[i];
      end else begin
        bnd[i] = gt_r[i-1] & ~gt_r[i];
      end
    end
    pos_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) begin
        pos_idx = pos_idx | IDX_W'(i);
      end
    end
  end

  assign hit  = |(bnd & eq_r);
  assign full = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    ent_nxt   = ent_r;
    count_nxt = count_r;
    ok        = 1'b0;
    unique case (op_r)
      spq_pkg::OP_INSERT: begin
        if (!full) begin
          ok        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (bnd[i]) begin
              ent_nxt[i] = val_r;
            end
          end
          for (int i = 1; i < CAPACITY; i++) begin
            if (!gt_r[i] && !bnd[i]) begin
              ent_nxt[i] = ent_r[i-1];
            end
          end
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (hit) begin
          ok        = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (!gt_r[i]) begin
              ent_nxt[i] = ent_r[i+1];
            end
          end
        end
      end
      spq_pkg::OP_FIND: begin
        ok = hit;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign pos_w = ok ? 32'(pos_idx) : 32'd0;
  assign len_w = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_mode;
      val_r <= in_value;
      gt_r  <= gt_nxt;
      eq_r  <= eq_nxt;
    end
    if (cmd.commit) begin
      ent_r        <= ent_nxt;
      res_success  <= ok;
      res_position <= pos_w[spq_pkg::POS_W-1:0];
      res_head     <= (count_nxt != '0) ? $signed(ent_nxt[0]) : '0;
      res_empty    <= (count_nxt == '0);
      res_length   <= len_w[spq_pkg::LEN_W-1:0];
    end
  end

endmodule

// ===== rtl/spq_ctrl.sv =====
// controller: two-state sequencer and output handshake
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output spq_pkg::cmd_t cmd
);

  spq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    unique case (state_r)
      spq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        // result register must be free or emptying this cycle
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue of signed 32-bit values, largest at position 0, holding up to
// CAPACITY entries. For each input word (mode in in_tuser, value in in_tdata), in the
// accept cycle the value is compared against every stored entry at once and the flags
// are registered; in the execute state after it, the entry array shifts by one place on
// a successful insert or remove and the result word is loaded into the output register.
// The next word is accepted while that result waits to be taken, but not during the
// execute state; a stalled output holds that state until the result register frees.
// Entries past the length never affect a result, so no clearing is needed after reset.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spq_pkg::DATA_W-1:0]      in_tdata,   // value
  input  logic [spq_pkg::MODE_W-1:0]      in_tuser,   // mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0] out_tdata   // success, position, head_value,
                                                      // is_empty, length, zero fill
);

  spq_pkg::cmd_t                     cmd;
  logic                              success;
  logic [spq_pkg::POS_W-1:0]         position;
  logic signed [spq_pkg::DATA_W-1:0] head_value;
  logic                              is_empty;
  logic [spq_pkg::LEN_W-1:0]         length;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_mode      (in_tuser),
    .in_value     ($signed(in_tdata)),
    .res_success  (success),
    .res_position (position),
    .res_head     (head_value),
    .res_empty    (is_empty),
    .res_length   (length)
  );

  assign out_tdata = {{(spq_pkg::OUT_TDATA_W - spq_pkg::RES_W){1'b0}},
                      length, is_empty, head_value, position, success};

  // no two words are accepted back to back
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // an empty queue reports zero length and a zero head
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && is_empty |-> (length == '0) && (head_value == '0))
    else $error("empty result with nonzero length or head");

  // a failed operation reports position zero
  a_fail_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !success |-> (position == '0))
    else $error("failed operation with nonzero position");

  // a new result only appears after the sequencer left its idle state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without an operation in progress");

endmodule

// ===== verif/tb_sorted_priority_queue.sv =====
// testbench for the sorted priority queue: directed table, then random traffic checked by a predictor
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

  localparam int          QUEUE_DEPTH   = spq_pkg::CAPACITY_DEF;
  localparam logic [1:0]  MODE_NOP      = 2'd3;
  localparam int          TIDE_FILL     = 0;
  localparam int          TIDE_DRAIN    = 1;
  localparam int          TIDE_MIX      = 2;
  localparam int          WORDS_PER_PH  = 188;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES  = 16;

  typedef struct packed {
    logic                       success;
    logic [spq_pkg::POS_W-1:0]  position;
    logic [spq_pkg::DATA_W-1:0] head_value;
    logic                       is_empty;
    logic [spq_pkg::LEN_W-1:0]  length;
  } queue_status_t;

  typedef struct packed {
    logic [spq_pkg::MODE_W-1:0] mode;
    logic [spq_pkg::DATA_W-1:0] value;
    logic                       pinned;
    queue_status_t              want;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [spq_pkg::DATA_W-1:0]      in_tdata;   // value
  logic [spq_pkg::MODE_W-1:0]      in_tuser;   // mode
  logic                            out_tvalid;
  logic                            out_tready;
  logic [spq_pkg::OUT_TDATA_W-1:0] out_tdata;  // success, position, head_value,
                                               // is_empty, length, zero fill

  // predictor state: sorted copy of the queue contents
  logic [spq_pkg::DATA_W-1:0] slots [0:QUEUE_DEPTH-1];
  int                         fill;

  queue_status_t     status_q [$];
  queue_status_t     pinned_status [int];
  stim_row_t         stim_rows [$];

  int in_idle_pct;
  int out_stall_pct;
  int words_sent;
  int words_taken;
  int results_seen;
  int errors;
  int quiet;
  int refused_full;
  int lookup_hits;
  int times_empty;

  sorted_priority_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit first_equal(input logic [spq_pkg::DATA_W-1:0] value, output int at);
    bit hit;
    hit = 0;
    at  = 0;
    for (int i = 0; i < fill; i++) begin
      if (!hit && slots[i] == value) begin
        hit = 1;
        at  = i;
      end
    end
    return hit;
  endfunction

  task automatic queue_apply(input logic [spq_pkg::MODE_W-1:0] mode,
                             input logic [spq_pkg::DATA_W-1:0] value,
                             output queue_status_t st);
    bit hit;
    bit placed;
    int at;
    hit = 0;
    at  = 0;
    case (mode)
      spq_pkg::OP_INSERT: begin
        if (fill < QUEUE_DEPTH) begin
          at     = fill;
          placed = 0;
          // goes before the first entry that is not larger, so ahead of equal ones
          for (int i = 0; i < fill; i++) begin
            if (!placed && $signed(slots[i]) <= $signed(value)) begin
              at     = i;
              placed = 1;
            end
          end
          for (int i = fill; i > at; i--) slots[i] = slots[i-1];
          slots[at] = value;
          fill++;
          hit = 1;
        end
      end
      spq_pkg::OP_REMOVE: begin
        hit = first_equal(value, at);
        if (hit) begin
          for (int i = at; i + 1 < fill; i++) slots[i] = slots[i+1];
          fill--;
        end
      end
      spq_pkg::OP_FIND: hit = first_equal(value, at);
      default: ;
    endcase
    if (!hit) at = 0;
    st.success    = hit;
    st.position   = at[spq_pkg::POS_W-1:0];
    st.head_value = (fill > 0) ? slots[0] : '0;
    st.is_empty   = (fill == 0);
    st.length     = fill[spq_pkg::LEN_W-1:0];
  endtask

  task automatic add_row(input logic [spq_pkg::MODE_W-1:0] mode,
                         input logic [spq_pkg::DATA_W-1:0] value,
                         input logic pinned, input logic success, input int position,
                         input logic [spq_pkg::DATA_W-1:0] head, input logic empty,
                         input int length);
    stim_row_t row;
    row.mode            = mode;
    row.value           = value;
    row.pinned          = pinned;
    row.want.success    = success;
    row.want.position   = position[spq_pkg::POS_W-1:0];
    row.want.head_value = head;
    row.want.is_empty   = empty;
    row.want.length     = length[spq_pkg::LEN_W-1:0];
    stim_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [spq_pkg::DATA_W-1:0] want_v,
                             input logic [spq_pkg::DATA_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  function automatic logic [spq_pkg::MODE_W-1:0] pick_mode(input int tide);
    int r;
    int ins;
    r   = $urandom_range(0, 99);
    ins = (tide == TIDE_FILL) ? 70 : (tide == TIDE_DRAIN) ? 20 : 40;
    if (r < 4) return MODE_NOP;
    if (r < 4 + ins) return spq_pkg::OP_INSERT;
    if ($urandom_range(0, 1) == 1) return spq_pkg::OP_REMOVE;
    return spq_pkg::OP_FIND;
  endfunction

  // mostly values already stored so that removes and finds hit
  function automatic logic [spq_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && fill > 0) return slots[$urandom_range(0, fill - 1)];
    if (r < 80) begin
      case ($urandom_range(0, 7))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        3:       return 32'hffff_ffff;
        4:       return 32'h0000_0001;
        5:       return 32'h0000_0002;
        6:       return 32'hffff_fffe;
        default: return 32'h0000_0100;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_word(input logic [spq_pkg::MODE_W-1:0] mode,
                           input logic [spq_pkg::DATA_W-1:0] value);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= spq_pkg::MODE_W'($urandom_range(0, 3));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    queue_status_t st;
    queue_status_t got;
    if (rst_n && in_tvalid && in_tready) begin
      queue_apply(in_tuser, in_tdata, st);
      if (in_tuser == spq_pkg::OP_INSERT && !st.success) refused_full++;
      if ((in_tuser == spq_pkg::OP_REMOVE || in_tuser == spq_pkg::OP_FIND) && st.success)
        lookup_hits++;
      if (st.is_empty) times_empty++;
      if (pinned_status.exists(words_taken)) st = pinned_status[words_taken];
      status_q.push_back(st);
      words_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.success    = out_tdata[0];
      got.position   = out_tdata[1 +: spq_pkg::POS_W];
      got.head_value = out_tdata[1 + spq_pkg::POS_W +: spq_pkg::DATA_W];
      got.is_empty   = out_tdata[1 + spq_pkg::POS_W + spq_pkg::DATA_W];
      got.length     = out_tdata[2 + spq_pkg::POS_W + spq_pkg::DATA_W +: spq_pkg::LEN_W];
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none got %0h", $time, out_tdata);
        errors++;
      end else begin
        st = status_q.pop_front();
        check_field("success", st.success, got.success);
        check_field("position", st.position, got.position);
        check_field("head_value", st.head_value, got.head_value);
        check_field("is_empty", st.is_empty, got.is_empty);
        check_field("length", st.length, got.length);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL sorted_priority_queue");
      $finish;
    end
  end

  initial begin
    int tide;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    fill          = 0;
    words_sent    = 0;
    words_taken   = 0;
    results_seen  = 0;
    errors        = 0;
    quiet         = 0;
    refused_full  = 0;
    lookup_hits   = 0;
    times_empty   = 0;
    tide          = TIDE_MIX;

    // empty queue, extremes, duplicates and the unused mode
    add_row(spq_pkg::OP_FIND,    32'h0000_0000, 1, 0, 0, 32'h0000_0000, 1, 0);
    add_row(spq_pkg::OP_REMOVE,  32'h0000_0005, 1, 0, 0, 32'h0000_0000, 1, 0);
    add_row(MODE_NOP,            32'h0000_0000, 1, 0, 0, 32'h0000_0000, 1, 0);
    add_row(spq_pkg::OP_INSERT,  32'h7fff_ffff, 1, 1, 0, 32'h7fff_ffff, 0, 1);
    add_row(spq_pkg::OP_INSERT,  32'h8000_0000, 1, 1, 1, 32'h7fff_ffff, 0, 2);
    add_row(spq_pkg::OP_INSERT,  32'h7fff_ffff, 1, 1, 0, 32'h7fff_ffff, 0, 3);
    add_row(spq_pkg::OP_FIND,    32'h8000_0000, 1, 1, 2, 32'h7fff_ffff, 0, 3);
    add_row(MODE_NOP,            32'hffff_ffff, 1, 0, 0, 32'h7fff_ffff, 0, 3);
    add_row(spq_pkg::OP_REMOVE,  32'h0001_2345, 1, 0, 0, 32'h7fff_ffff, 0, 3);
    add_row(spq_pkg::OP_REMOVE,  32'h7fff_ffff, 1, 1, 0, 32'h7fff_ffff, 0, 2);
    // fill to capacity
    add_row(spq_pkg::OP_INSERT,  32'h0000_0000, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'hffff_ffff, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'h0000_0001, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'h4000_0000, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'hc000_0000, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'h5555_5555, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'haaaa_aaaa, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'h0000_0005, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'h0000_0005, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'h0000_0001, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'hffff_fffe, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'h7fff_fffe, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'h8000_0001, 0, 0, 0, 0, 0, 0);
    add_row(spq_pkg::OP_INSERT,  32'h0000_ffff, 0, 0, 0, 0, 0, 0);
    // full: refused insert, then the smallest comes out of the last place
    add_row(spq_pkg::OP_INSERT,  32'h1234_5678, 1, 0, 0, 32'h7fff_ffff, 0, 16);
    add_row(spq_pkg::OP_REMOVE,  32'h8000_0000, 1, 1, 15, 32'h7fff_ffff, 0, 15);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[k]) begin
      if (stim_rows[k].pinned) pinned_status[words_sent] = stim_rows[k].want;
      send_word(stim_rows[k].mode, stim_rows[k].value);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 46; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 46; end
        default: begin in_idle_pct = 27; out_stall_pct = 27; end
      endcase
      for (int k = 0; k < WORDS_PER_PH; k++) begin
        // swing between filling and draining so both full and empty come up
        if (k % 20 == 0) tide = $urandom_range(TIDE_FILL, TIDE_MIX);
        send_word(pick_mode(tide), pick_value());
      end
    end
    in_tvalid <= 1'b0;

    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words, checked %0d results", words_sent, results_seen);
    $display("inserts refused when full: %0d, remove/find hits: %0d, empty results: %0d",
             refused_full, lookup_hits, times_empty);
    if (errors == 0 && status_q.size() == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_dp.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
verif/tb_sorted_priority_queue.sv
